// ===== src/lhp_pkg.sv =====
package lhp_pkg;

    // Default store size: one bucket per 100 us up to 2 s, plus an overflow bucket
    localparam int BUCKET_COUNT_DEF = 20002;

    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 32;
    localparam int FRAC_W   = 14;
    localparam int SUM_W    = 63;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 160;

    localparam logic [SAMPLE_W-1:0] OVERFLOW_LIMIT_US = 32'd2000000;
    localparam int                  BUCKET_WIDTH_US   = 100;
    localparam logic [FRAC_W-1:0]   FRACTION_FULL     = 14'd10000;

    // Divide by 100 through a reciprocal: exact for dividends below about 6e6
    localparam int               SMALL_W     = 21;
    localparam int               RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP_100 = 22'd2684355;
    localparam int               RECIP_SHIFT = 28;
    localparam int               QUOT_W      = 15;

    // Fraction times count, and bucket count times 10000
    localparam int SCALED_W = COUNT_W + FRAC_W;

    typedef enum logic
    {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed
    {
        logic clr_wr;
        logic add_accept;
        logic add_commit;
        logic query_accept;
        logic rank_load;
        logic walk_step;
        logic query_commit;
    } cmd_t;

    typedef struct packed
    {
        logic clr_last;
        logic empty;
        logic found;
    } status_t;

endpackage

// ===== src/lhp_ram.sv =====
module lhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/lhp_ctrl.sv =====
module lhp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_op,
    input  logic             m_tready,
    input  lhp_pkg::status_t status,
    output logic             s_tready,
    output logic             m_tvalid,
    output lhp_pkg::cmd_t    cmd
);

    import lhp_pkg::*;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_RANK,
        ST_WALK,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_op == OP_ADD)
                    begin
                        cmd.add_accept = 1'b1;
                        state_next     = ST_ADD;
                    end
                    else
                    begin
                        cmd.query_accept = 1'b1;
                        state_next       = status.empty ? ST_RESULT : ST_RANK;
                    end
                end
            end
            ST_ADD:
            begin
                // hold the bucket read until the result register frees up
                if (out_free)
                begin
                    cmd.add_commit = 1'b1;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RANK:
            begin
                cmd.rank_load = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.found)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.query_commit = 1'b1;
                    m_tvalid_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== src/lhp_dp.sv =====
module lhp_dp #(
    parameter int BUCKET_COUNT = lhp_pkg::BUCKET_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lhp_pkg::cmd_t                  cmd,
    output lhp_pkg::status_t               status,
    input  logic [lhp_pkg::SAMPLE_W-1:0]   in_sample_us,
    input  logic [lhp_pkg::FRAC_W-1:0]     in_fraction_bp,
    output logic [lhp_pkg::SAMPLE_W-1:0]   percentile_us,
    output logic [lhp_pkg::COUNT_W-1:0]    sample_count,
    output logic [lhp_pkg::SAMPLE_W-1:0]   max_us,
    output logic [lhp_pkg::SUM_W-1:0]      sum_us
);

    import lhp_pkg::*;

    localparam int             IW     = $clog2(BUCKET_COUNT);
    localparam logic [IW-1:0]  LAST   = IW'(BUCKET_COUNT - 1);
    localparam int             CUM_W  = IW + SCALED_W;
    localparam int             EDGE_W = IW + 7;
    localparam int             PROD_W = SMALL_W + RECIP_W;

    // bucket index for an incoming sample
    logic [SMALL_W-1:0] round_up;
    logic [PROD_W-1:0]  recip_prod;
    logic [QUOT_W-1:0]  quot;
    logic [IW-1:0]      add_idx;

    // held request
    logic [SAMPLE_W-1:0] us_reg;
    logic [IW-1:0]       idx_reg;
    logic [FRAC_W-1:0]   bp_reg;

    // running statistics
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W:0]      sum_wide;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] max_next;

    // bucket store
    logic               ram_wr_en;
    logic [IW-1:0]      ram_wr_addr;
    logic [COUNT_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [IW-1:0]      ram_rd_addr;
    logic [COUNT_W-1:0] ram_rd_data;
    logic [COUNT_W-1:0] bucket_inc;
    logic [IW-1:0]      clr_addr_reg;

    // percentile walk
    logic [SCALED_W-1:0] rank_prod;
    logic [SCALED_W-1:0] target_reg;
    logic [IW-1:0]       walk_addr_reg;
    logic                issue_on_reg;
    logic                v1_reg;
    logic [IW-1:0]       idx1_reg;
    logic                v2_reg;
    logic [IW-1:0]       idx2_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [CUM_W-1:0]    cum_reg;
    logic [CUM_W-1:0]    cum_next;
    logic                hit;
    logic                found_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic [EDGE_W-1:0]   edge_us;
    logic [SAMPLE_W-1:0] edge_ext;
    logic [SAMPLE_W-1:0] query_ans;

    // result register
    logic [SAMPLE_W-1:0] pct_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;
    logic [SAMPLE_W-1:0] max_out_reg;
    logic [SUM_W-1:0]    sum_out_reg;

    // ceil(us/100) as floor((us+99)/100) by reciprocal multiply
    assign round_up   = in_sample_us[SMALL_W-1:0] + SMALL_W'(BUCKET_WIDTH_US - 1);
    assign recip_prod = PROD_W'(round_up) * PROD_W'(RECIP_100);
    assign quot       = recip_prod[RECIP_SHIFT +: QUOT_W];

    always_comb
    begin
        if ((in_sample_us > OVERFLOW_LIMIT_US) || (32'(quot) > 32'(BUCKET_COUNT - 1)))
        begin
            add_idx = LAST;
        end
        else
        begin
            add_idx = IW'(quot);
        end
    end

    // saturating statistics update
    assign count_next = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
    assign sum_wide   = {1'b0, sum_reg} + (SUM_W + 1)'(us_reg);
    assign sum_next   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    assign max_next   = (us_reg > max_reg) ? us_reg : max_reg;
    assign bucket_inc = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + COUNT_W'(1);

    assign ram_wr_en   = cmd.clr_wr || cmd.add_commit;
    assign ram_wr_addr = cmd.clr_wr ? clr_addr_reg : idx_reg;
    assign ram_wr_data = cmd.clr_wr ? '0 : bucket_inc;
    assign ram_rd_en   = cmd.add_accept || (cmd.walk_step && issue_on_reg);
    assign ram_rd_addr = cmd.add_accept ? add_idx : walk_addr_reg;

    lhp_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BUCKET_COUNT)
    ) u_bucket_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // rank test without a divide: cum >= ceil(p/10000) iff cum*10000 >= p
    assign rank_prod = SCALED_W'(bp_reg) * SCALED_W'(count_reg);
    assign cum_next  = cum_reg + CUM_W'(scaled_reg);
    assign hit       = v2_reg && !found_reg &&
                       ((cum_next >= CUM_W'(target_reg)) || (idx2_reg == LAST));

    assign edge_us   = EDGE_W'(hit_idx_reg) * EDGE_W'(BUCKET_WIDTH_US);
    assign edge_ext  = SAMPLE_W'(edge_us);

    always_comb
    begin
        if (count_reg == '0)
        begin
            query_ans = '0;
        end
        else if ((hit_idx_reg == LAST) || (edge_ext >= max_reg))
        begin
            query_ans = max_reg;
        end
        else
        begin
            query_ans = edge_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            max_reg      <= '0;
            issue_on_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr && (clr_addr_reg != LAST))
            begin
                clr_addr_reg <= clr_addr_reg + IW'(1);
            end
            if (cmd.add_commit)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                max_reg   <= max_next;
            end
            if (cmd.rank_load)
            begin
                issue_on_reg <= 1'b1;
                v1_reg       <= 1'b0;
                v2_reg       <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.walk_step)
            begin
                if (issue_on_reg && (walk_addr_reg == LAST))
                begin
                    issue_on_reg <= 1'b0;
                end
                v1_reg <= issue_on_reg;
                v2_reg <= v1_reg;
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_accept)
        begin
            us_reg  <= in_sample_us;
            idx_reg <= add_idx;
        end
        if (cmd.query_accept)
        begin
            bp_reg <= (in_fraction_bp > FRACTION_FULL) ? FRACTION_FULL : in_fraction_bp;
        end
        if (cmd.rank_load)
        begin
            target_reg    <= (rank_prod == '0) ? SCALED_W'(1) : rank_prod;
            walk_addr_reg <= '0;
            cum_reg       <= '0;
        end
        else if (cmd.walk_step)
        begin
            if (issue_on_reg && (walk_addr_reg != LAST))
            begin
                walk_addr_reg <= walk_addr_reg + IW'(1);
            end
            idx1_reg   <= walk_addr_reg;
            idx2_reg   <= idx1_reg;
            scaled_reg <= SCALED_W'(ram_rd_data) * SCALED_W'(FRACTION_FULL);
            if (v2_reg && !found_reg)
            begin
                cum_reg <= cum_next;
            end
            if (hit)
            begin
                hit_idx_reg <= idx2_reg;
            end
        end
        if (cmd.add_commit)
        begin
            pct_out_reg   <= '0;
            count_out_reg <= count_next;
            max_out_reg   <= max_next;
            sum_out_reg   <= sum_next;
        end
        else if (cmd.query_commit)
        begin
            pct_out_reg   <= query_ans;
            count_out_reg <= count_reg;
            max_out_reg   <= max_reg;
            sum_out_reg   <= sum_reg;
        end
    end

    assign status.clr_last = (clr_addr_reg == LAST);
    assign status.empty    = (count_reg == '0);
    assign status.found    = found_reg;

    assign percentile_us = pct_out_reg;
    assign sample_count  = count_out_reg;
    assign max_us        = max_out_reg;
    assign sum_us        = sum_out_reg;

endmodule

// ===== src/latency_histogram_percentile_top.sv =====
// Add request: accepted, then one bucket memory word is read, incremented and written back
//   and the result registered once the result register is free; s_tready stays low meanwhile.
// Query request: with no samples it goes straight to the result; otherwise the walk scans the
//   bucket memory one bucket per cycle until the rank is reached, then registers the result.
// Reset (rst_n low, asynchronous) clears statistics, then a clearing pass writes
//   zero to all BUCKET_COUNT buckets, one per cycle, with s_tready held low.
module latency_histogram_percentile_top #(
    parameter int BUCKET_COUNT = lhp_pkg::BUCKET_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] sample_us, [45:32] fraction_bp, [47:46] zero
    input  logic [lhp_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] operation: 0 add sample, 1 percentile query
    input  logic                              s_tuser,

    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] percentile_us, [63:32] sample_count, [95:64] max_us,
    // [158:96] sum_us, [159] zero
    output logic [lhp_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import lhp_pkg::*;

    cmd_t                cmd;
    status_t             status;
    logic [SAMPLE_W-1:0] percentile_us;
    logic [COUNT_W-1:0]  sample_count;
    logic [SAMPLE_W-1:0] max_us;
    logic [SUM_W-1:0]    sum_us;

    // Sequencer: clearing pass, request decode, result handshake
    lhp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // Datapath: bucket index, bucket memory, statistics, percentile walk,
    // and the result register that lets the next request in while one waits
    lhp_dp #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_sample_us   (s_tdata[SAMPLE_W-1:0]),
        .in_fraction_bp (s_tdata[SAMPLE_W +: FRAC_W]),
        .percentile_us  (percentile_us),
        .sample_count   (sample_count),
        .max_us         (max_us),
        .sum_us         (sum_us)
    );

    assign m_tdata = {1'b0, sum_us, max_us, sample_count, percentile_us};

endmodule
